// File: hw/rtl/sqlis_pkg.sv
package sqlis_pkg;

  // Scan limit: a match must end at least one byte before this many bytes.
  localparam int unsigned ScanWindow = 128;
  localparam int unsigned CountW     = $clog2(ScanWindow + 1);
  localparam int unsigned PosW       = 7;
  localparam int unsigned CalcW      = (CountW > PosW) ? CountW : PosW;
  localparam int unsigned WinDepth   = 4;

  typedef enum logic [2:0] {
    CodeNone    = 3'd0,
    CodeUnion   = 3'd1,
    CodeOrTrue  = 3'd2,
    CodeComment = 3'd3,
    CodeStacked = 3'd4,
    CodeSleep   = 3'd5
  } match_code_e;

  localparam logic [7:0]  CharSpace  = 8'd32;
  localparam logic [7:0]  CaseOffset = 8'd32;
  localparam logic [7:0]  CharUpperA = "A";
  localparam logic [7:0]  CharUpperZ = "Z";
  localparam logic [7:0]  CharO      = "o";
  localparam logic [7:0]  CharR      = "r";
  localparam logic [7:0]  CharT      = "t";
  localparam logic [7:0]  CharOne    = "1";
  localparam logic [7:0]  CharEq     = "=";
  localparam logic [7:0]  CharDash   = "-";
  localparam logic [7:0]  CharSlash  = "/";
  localparam logic [7:0]  CharStar   = "*";
  localparam logic [7:0]  CharSemi   = ";";
  localparam logic [7:0]  CharD      = "d";
  localparam logic [7:0]  CharI      = "i";
  localparam logic [7:0]  CharU      = "u";
  localparam logic [7:0]  CharC      = "c";
  localparam logic [39:0] WordUnion  = "union";
  localparam logic [39:0] WordSleep  = "sleep";

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } step_t;

  typedef struct packed {
    match_code_e       code;
    logic [PosW-1:0]   position;
    logic              detected;
  } result_t;

  // Only A-Z are folded to lower case.
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      r = c + CaseOffset;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/sqlis_if.sv
interface sqlis_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, output char_in, output last_char, input ready);
  modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface sqlis_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] match_code;
  logic [6:0] match_position;
  logic       detected;

  modport source (output valid, output match_code, output match_position,
                  output detected, input ready);
  modport sink   (input valid, input match_code, input match_position,
                  input detected, output ready);
endinterface

// File: hw/rtl/sqlis_classifier.sv
module sqlis_classifier (
  input  logic [4:0][7:0]          win_i,
  input  logic                     start_gt3_i,
  output sqlis_pkg::match_code_e   code_o
);

  logic [4:0][7:0] fw;
  logic            is_union;
  logic            is_sleep;
  logic            is_or_true;
  logic            is_comment;
  logic            is_stacked;
  logic [7:0]      stack_char;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      fw[k] = sqlis_pkg::fold_char(win_i[k]);
    end
  end

  always_comb begin
    is_union = 1'b1;
    is_sleep = 1'b1;
    for (int k = 0; k < 5; k++) begin
      if (fw[k] != sqlis_pkg::WordUnion[8*(4-k) +: 8]) is_union = 1'b0;
      if (fw[k] != sqlis_pkg::WordSleep[8*(4-k) +: 8]) is_sleep = 1'b0;
    end
  end

  assign is_or_true = (fw[0] == sqlis_pkg::CharO) && (fw[1] == sqlis_pkg::CharR) &&
                      (win_i[2] == sqlis_pkg::CharSpace) &&
                      (((win_i[3] == sqlis_pkg::CharOne) && (win_i[4] == sqlis_pkg::CharEq)) ||
                       (fw[3] == sqlis_pkg::CharT));

  assign is_comment = ((win_i[0] == sqlis_pkg::CharDash) && (win_i[1] == sqlis_pkg::CharDash)) ||
                      ((win_i[0] == sqlis_pkg::CharSlash) && (win_i[1] == sqlis_pkg::CharStar));

  // Skip up to two spaces after the semicolon.
  always_comb begin
    if (win_i[1] != sqlis_pkg::CharSpace) begin
      stack_char = fw[1];
    end else if (win_i[2] != sqlis_pkg::CharSpace) begin
      stack_char = fw[2];
    end else begin
      stack_char = fw[3];
    end
  end

  assign is_stacked = (win_i[0] == sqlis_pkg::CharSemi) && start_gt3_i &&
                      ((stack_char == sqlis_pkg::CharD) || (stack_char == sqlis_pkg::CharI) ||
                       (stack_char == sqlis_pkg::CharU) || (stack_char == sqlis_pkg::CharC));

  always_comb begin
    priority if (is_union) begin
      code_o = sqlis_pkg::CodeUnion;
    end else if (is_sleep) begin
      code_o = sqlis_pkg::CodeSleep;
    end else if (is_or_true) begin
      code_o = sqlis_pkg::CodeOrTrue;
    end else if (is_comment) begin
      code_o = sqlis_pkg::CodeComment;
    end else if (is_stacked) begin
      code_o = sqlis_pkg::CodeStacked;
    end else begin
      code_o = sqlis_pkg::CodeNone;
    end
  end

endmodule

// File: hw/rtl/sqlis_scan_core.sv
module sqlis_scan_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_valid_i,
  input  sqlis_pkg::step_t    step_i,
  output sqlis_pkg::result_t  result_o
);

  logic [sqlis_pkg::WinDepth-1:0][7:0] win_q, win_d;
  logic [sqlis_pkg::CountW-1:0]        count_q, count_d;
  sqlis_pkg::match_code_e              code_q, code_d;
  logic [sqlis_pkg::PosW-1:0]          pos_q, pos_d;

  logic [4:0][7:0]                     window;
  logic [sqlis_pkg::CalcW-1:0]         start;
  logic                                scan_en;
  sqlis_pkg::match_code_e              code_new;

  // Window element 0 is the oldest byte, element 4 the incoming one.
  assign window = {step_i.char_in, win_q[3], win_q[2], win_q[1], win_q[0]};
  assign start  = sqlis_pkg::CalcW'(count_q) - sqlis_pkg::CalcW'(4);

  assign scan_en = (code_q == sqlis_pkg::CodeNone) && !step_i.last_char &&
                   (count_q >= sqlis_pkg::CountW'(4)) &&
                   (count_q <= sqlis_pkg::CountW'(sqlis_pkg::ScanWindow - 2));

  sqlis_classifier u_classifier (
    .win_i       (window),
    .start_gt3_i (count_q >= sqlis_pkg::CountW'(8)),
    .code_o      (code_new)
  );

  always_comb begin
    win_d   = win_q;
    count_d = count_q;
    code_d  = code_q;
    pos_d   = pos_q;
    if (step_valid_i) begin
      if (step_i.last_char) begin
        win_d   = '0;
        count_d = '0;
        code_d  = sqlis_pkg::CodeNone;
        pos_d   = '0;
      end else begin
        win_d = {step_i.char_in, win_q[3], win_q[2], win_q[1]};
        if (count_q < sqlis_pkg::CountW'(sqlis_pkg::ScanWindow)) begin
          count_d = count_q + sqlis_pkg::CountW'(1);
        end
        if (scan_en && (code_new != sqlis_pkg::CodeNone)) begin
          code_d = code_new;
          pos_d  = start[sqlis_pkg::PosW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      count_q <= '0;
      code_q  <= sqlis_pkg::CodeNone;
      pos_q   <= '0;
    end else begin
      win_q   <= win_d;
      count_q <= count_d;
      code_q  <= code_d;
      pos_q   <= pos_d;
    end
  end

  assign result_o.code     = code_q;
  assign result_o.position = pos_q;
  assign result_o.detected = (code_q != sqlis_pkg::CodeNone);

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_i && step_i.last_char |=> (count_q == '0) && (code_q == sqlis_pkg::CodeNone))
    else $error("scan state not cleared after final byte");

  a_match_needs_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_q != sqlis_pkg::CodeNone) |-> (count_q >= sqlis_pkg::CountW'(5)))
    else $error("match recorded with too few bytes seen");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sqlis_pkg::CountW'(sqlis_pkg::ScanWindow))
    else $error("byte count passed the scan limit");
`endif

endmodule

// File: hw/rtl/sql_injection_signature_scan.sv
// A result transaction is driven from the output register, which takes the match record
// when the final byte leaves the input register while the output register is free.
// Throughput: one byte per cycle; the only stall is a final byte held while the
// previous result still waits in the output register.
// Reset: rst_ni is asynchronous and active low; it clears the window, count, match
// record and both valid flags at once, with no clearing pass.
module sql_injection_signature_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sqlis_char_if.sink            char_i,
  sqlis_result_if.source        result_o
);

  // The design has two register stages around the scan logic. The input
  // register holds one accepted byte. In the next cycle that byte updates the
  // four-byte window, the byte count and the first-match record inside the
  // scan core, where a shallow compare tree tests the five-byte window that
  // ends at the byte. A byte that carries the last flag does not scan; instead
  // the match record is copied into the output register and the scan state
  // returns to its reset value for the next query.

  logic                 in_valid_q;
  sqlis_pkg::step_t     in_step_q;
  logic                 out_valid_q;
  sqlis_pkg::result_t   out_q;
  sqlis_pkg::result_t   core_result;
  logic                 out_free;
  logic                 advance;
  logic                 in_ready;

  // A non-final byte never needs the output register, so it always moves on.
  // A final byte moves on only when the output register is empty or being
  // drained in this cycle, which acts as the skid between the two sides.
  assign out_free = !out_valid_q || result_o.ready;
  assign advance  = in_valid_q && (!in_step_q.last_char || out_free);
  assign in_ready = !in_valid_q || advance;

  assign char_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && char_i.valid) begin
      in_step_q.char_in   <= char_i.char_in;
      in_step_q.last_char <= char_i.last_char;
    end
  end

  sqlis_scan_core u_scan_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (advance),
    .step_i       (in_step_q),
    .result_o     (core_result)
  );

  // The output register takes the match record when a final byte moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_step_q.last_char) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_step_q.last_char) begin
      out_q <= core_result;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.match_code     = 3'(out_q.code);
  assign result_o.match_position = out_q.position;
  assign result_o.detected       = out_q.detected;

`ifndef SYNTH
  a_detected_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.detected == (result_o.match_code != 3'(sqlis_pkg::CodeNone))))
    else $error("detected flag disagrees with match code");

  a_no_match_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.match_code == 3'(sqlis_pkg::CodeNone))
      |-> (result_o.match_position == '0))
    else $error("position reported without a match");

  a_final_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_step_q.last_char && out_valid_q && !result_o.ready
      |=> in_valid_q && in_step_q.last_char)
    else $error("final byte lost while result stalled");
`endif

endmodule
